[design/bsks_pkg.sv]
// Shared types and codes for the bounded key-search stack.
// Used by the channel interfaces, the stack cell and the top level.
package bsks_pkg;

  localparam int KEY_W      = 32;
  localparam int PAYLOAD_W  = 64;
  localparam int KIND_W     = 3;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 5;
  localparam int CAPACITY_DEF = 16;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH   = 3'd0,
    KIND_POP    = 3'd1,
    KIND_CLEAR  = 3'd2,
    KIND_SEARCH = 3'd3,
    KIND_DELETE = 3'd4
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2,
    ST_MISS  = 2'd3
  } status_e;

  // What every cell does with its entry
  typedef enum logic [2:0] {
    OP_HOLD  = 3'd0,
    OP_PUSH  = 3'd1,   // take the entry from the cell nearer the top
    OP_POP   = 3'd2,   // take the entry from the cell nearer the bottom
    OP_CLEAR = 3'd3,
    OP_DEL   = 3'd4    // take from below if a match sits here or nearer the top
  } cell_op_e;

  typedef struct packed {
    logic                 valid;
    logic [KEY_W-1:0]     key;
    logic [PAYLOAD_W-1:0] payload;
  } entry_t;

  typedef struct packed {
    cell_op_e         op;
    logic [KEY_W-1:0] key;
  } cell_ctrl_t;

endpackage

[design/bsks_req_if.sv]
// Request channel: operation word with valid/ready handshake.
// Depends on bsks_pkg for field widths.
interface bsks_req_if
  import bsks_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    kind;
  logic [KEY_W-1:0]     key_in;
  logic [PAYLOAD_W-1:0] payload_in;

  modport source (output valid, kind, key_in, payload_in, input ready);
  modport sink   (input valid, kind, key_in, payload_in, output ready);
endinterface

[design/bsks_rsp_if.sv]
// Response channel: result word with valid/ready handshake.
// Depends on bsks_pkg for field widths.
interface bsks_rsp_if
  import bsks_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic                 found;
  logic [KEY_W-1:0]     key_out;
  logic [PAYLOAD_W-1:0] payload_out;
  logic [COUNT_W-1:0]   count;
  logic                 is_full;
  logic                 is_empty;

  modport source (output valid, status, found, key_out, payload_out, count, is_full,
                  is_empty, input ready);
  modport sink   (input valid, status, found, key_out, payload_out, count, is_full,
                  is_empty, output ready);
endinterface

[design/bsks_cell.sv]
// One stack slot: holds an entry, compares its key and shifts with its neighbors.
// Depends on bsks_pkg.
module bsks_cell
  import bsks_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  entry_t     above_i,
  input  entry_t     below_i,
  input  logic       hit_i,
  output logic       hit_o,
  output entry_t     entry_o
);

  logic                 valid_q, valid_d;
  logic [KEY_W-1:0]     key_q, key_d;
  logic [PAYLOAD_W-1:0] payload_q, payload_d;

  // hit_o: a live match here or anywhere nearer the top
  assign hit_o = hit_i | (valid_q & (key_q == ctrl_i.key));

  always_comb begin
    valid_d   = valid_q;
    key_d     = key_q;
    payload_d = payload_q;
    case (ctrl_i.op)
      OP_PUSH: begin
        valid_d   = above_i.valid;
        key_d     = above_i.key;
        payload_d = above_i.payload;
      end
      OP_POP: begin
        valid_d   = below_i.valid;
        key_d     = below_i.key;
        payload_d = below_i.payload;
      end
      OP_CLEAR: valid_d = 1'b0;
      OP_DEL: begin
        if (hit_o) begin
          valid_d   = below_i.valid;
          key_d     = below_i.key;
          payload_d = below_i.payload;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    payload_q <= payload_d;
  end

  assign entry_o = '{valid: valid_q, key: key_q, payload: payload_q};

endmodule

[design/bounded_stack_key_search_delete_top.sv]
// Top level of the bounded key-search stack: cell chain, count and result register.
// Depends on bsks_pkg, bsks_req_if, bsks_rsp_if and bsks_cell.

// A LIFO of CAPACITY entries (32-bit key, 64-bit payload) built as a chain of
// cells with the top of stack in cell 0. A push, pop, clear, search or delete
// word is accepted every cycle as long as the result register is empty or
// being drained, and its result appears in that register on the next cycle.
// Push and pop shift the whole chain by one place; delete shifts only the cells
// from the top-most match down. The clock limit is set by the match chain,
// which ripples a key compare result through all cells. Push on a full stack
// reports overflow and pop on an empty one underflow; neither changes the
// contents. No clearing pass follows reset.
module bounded_stack_key_search_delete_top
  import bsks_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bsks_req_if.sink   req_i,
  bsks_rsp_if.source rsp_o
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  entry_t             ent   [CAPACITY];
  entry_t             above [CAPACITY];
  entry_t             below [CAPACITY];
  logic [CAPACITY:0]  hit;
  logic [CAPACITY-1:0] vld;
  cell_ctrl_t         ctrl;

  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q;
  logic             accept;
  logic             full, empty;

  status_e              status_d;
  logic                 found_d;
  logic [KEY_W-1:0]     key_out_d;
  logic [PAYLOAD_W-1:0] payload_out_d;

  logic [STATUS_W-1:0]  status_q;
  logic                 found_q;
  logic [KEY_W-1:0]     key_out_q;
  logic [PAYLOAD_W-1:0] payload_out_q;
  logic [COUNT_W-1:0]   count_out_q;
  logic                 full_out_q, empty_out_q;

  assign req_i.ready = !out_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;
  assign full        = (count_q == CAP_CNT);
  assign empty       = (count_q == '0);
  assign hit[0]      = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_top
      assign above[i] = '{valid: 1'b1, key: req_i.key_in, payload: req_i.payload_in};
    end else begin : g_mid
      assign above[i] = ent[i-1];
    end
    if (i == CAPACITY - 1) begin : g_bot
      assign below[i] = '0;
    end else begin : g_nbot
      assign below[i] = ent[i+1];
    end

    bsks_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .above_i (above[i]),
      .below_i (below[i]),
      .hit_i   (hit[i]),
      .hit_o   (hit[i+1]),
      .entry_o (ent[i])
    );

    assign vld[i] = ent[i].valid;
  end

  always_comb begin
    ctrl.op       = OP_HOLD;
    ctrl.key      = req_i.key_in;
    count_d       = count_q;
    status_d      = ST_OK;
    found_d       = 1'b0;
    key_out_d     = '0;
    payload_out_d = '0;
    case (req_i.kind)
      KIND_PUSH: begin
        if (full) begin
          status_d = ST_OVER;
        end else begin
          ctrl.op = OP_PUSH;
          count_d = count_q + 1'b1;
        end
      end
      KIND_POP: begin
        if (empty) begin
          status_d = ST_UNDER;
        end else begin
          ctrl.op       = OP_POP;
          count_d       = count_q - 1'b1;
          key_out_d     = ent[0].key;
          payload_out_d = ent[0].payload;
        end
      end
      KIND_CLEAR: begin
        ctrl.op = OP_CLEAR;
        count_d = '0;
      end
      KIND_SEARCH: begin
        found_d = hit[CAPACITY];
        if (!hit[CAPACITY]) status_d = ST_MISS;
      end
      KIND_DELETE: begin
        found_d = hit[CAPACITY];
        if (hit[CAPACITY]) begin
          ctrl.op = OP_DEL;
          count_d = count_q - 1'b1;
        end else begin
          status_d = ST_MISS;
        end
      end
      default: ;
    endcase
    if (!accept) begin
      ctrl.op = OP_HOLD;
      count_d = count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q      <= status_d;
      found_q       <= found_d;
      key_out_q     <= key_out_d;
      payload_out_q <= payload_out_d;
      count_out_q   <= COUNT_W'(count_d);
      full_out_q    <= (count_d == CAP_CNT);
      empty_out_q   <= (count_d == '0);
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = status_q;
  assign rsp_o.found       = found_q;
  assign rsp_o.key_out     = key_out_q;
  assign rsp_o.payload_out = payload_out_q;
  assign rsp_o.count       = count_out_q;
  assign rsp_o.is_full     = full_out_q;
  assign rsp_o.is_empty    = empty_out_q;

`ifndef SYNTHESIS
  // live cells must match the count
  a_count_matches_cells: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(vld) == int'(count_q))
    else $error("cell valid bits disagree with count");

  // top cell is live exactly when the stack holds something
  a_top_cell_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld[0] == !empty)
    else $error("top cell state disagrees with empty flag");

  a_over_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status == ST_OVER) |-> rsp_o.is_full)
    else $error("overflow reported while not full");

  a_found_is_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.found) |-> (rsp_o.status == ST_OK))
    else $error("match reported with error status");
`endif

endmodule

[tb/bsks_tb_pkg.sv]
// Scoreboard for the bounded key-search stack testbench: a stack model and the results it awaits.
// Depends on bsks_pkg for field widths, kind and status codes.
package bsks_tb_pkg;
  import bsks_pkg::*;

  typedef struct packed {
    status_e              status;
    logic                 found;
    logic [KEY_W-1:0]     key_out;
    logic [PAYLOAD_W-1:0] payload_out;
    logic [COUNT_W-1:0]   count;
    logic                 is_full;
    logic                 is_empty;
  } stack_result_t;

  class stack_scoreboard;
    int capacity;
    logic [KEY_W-1:0]     slot_key[];
    logic [PAYLOAD_W-1:0] slot_payload[];
    int fill;
    stack_result_t awaited_results[$];

    int kind_count[8];
    int overflows, underflows, misses, hits, deepest;
    int checked, errors;

    function new(int cap);
      capacity = cap;
      slot_key = new[cap];
      slot_payload = new[cap];
      fill = 0;
      overflows = 0; underflows = 0; misses = 0; hits = 0; deepest = 0;
      checked = 0; errors = 0;
      foreach (kind_count[i]) kind_count[i] = 0;
    endfunction

    function int pending_count();
      return awaited_results.size();
    endfunction

    // Apply one accepted request word to the stack copy and queue its result
    function void note_request(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] key,
                               logic [PAYLOAD_W-1:0] payload);
      stack_result_t r;
      int pos;
      r = '0;
      r.status = ST_OK;
      pos = -1;
      kind_count[kind]++;
      case (kind)
        KIND_PUSH: begin
          if (fill >= capacity) begin
            r.status = ST_OVER;
          end else begin
            slot_key[fill] = key;
            slot_payload[fill] = payload;
            fill++;
          end
        end
        KIND_POP: begin
          if (fill == 0) begin
            r.status = ST_UNDER;
          end else begin
            fill--;
            r.key_out = slot_key[fill];
            r.payload_out = slot_payload[fill];
          end
        end
        KIND_CLEAR: fill = 0;
        KIND_SEARCH, KIND_DELETE: begin
          // top-most match wins
          for (int i = fill - 1; i >= 0 && pos < 0; i--)
            if (slot_key[i] == key) pos = i;
          if (pos < 0) begin
            r.status = ST_MISS;
          end else begin
            r.found = 1'b1;
            if (kind == KIND_DELETE) begin
              for (int j = pos; j + 1 < fill; j++) begin
                slot_key[j] = slot_key[j + 1];
                slot_payload[j] = slot_payload[j + 1];
              end
              fill--;
            end
          end
        end
        default: ;
      endcase
      r.count = COUNT_W'(fill);
      r.is_full = (fill >= capacity);
      r.is_empty = (fill == 0);
      case (r.status)
        ST_OVER:  overflows++;
        ST_UNDER: underflows++;
        ST_MISS:  misses++;
        default:  ;
      endcase
      if (r.found) hits++;
      if (fill > deepest) deepest = fill;
      awaited_results.push_back(r);
    endfunction

    function string show(stack_result_t r);
      return $sformatf("status %0d found %0b key %08h payload %016h count %0d full %0b empty %0b",
                       r.status, r.found, r.key_out, r.payload_out, r.count, r.is_full,
                       r.is_empty);
    endfunction

    function void check_response(stack_result_t got);
      stack_result_t want;
      bit bad;
      if (awaited_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word: %s", show(got));
        return;
      end
      want = awaited_results.pop_front();
      bad = (got.status !== want.status) || (got.found !== want.found) ||
            (got.key_out !== want.key_out) || (got.payload_out !== want.payload_out) ||
            (got.count !== want.count) || (got.is_full !== want.is_full) ||
            (got.is_empty !== want.is_empty);
      if (bad) begin
        errors++;
        if (errors <= 10) begin
          $display("result %0d differs", checked);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
      checked++;
    endfunction
  endclass

endpackage

[tb/bounded_stack_key_search_delete_top_tb.sv]
// Testbench top for the bounded key-search stack: directed and random request words,
// random stalls on both channels, results checked against the scoreboard in bsks_tb_pkg.
module bounded_stack_key_search_delete_top_tb
  import bsks_pkg::*, bsks_tb_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_WORDS   = 1500;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 10;
  localparam int POOL_SIZE      = 6;

  // kind codes the block treats as no operation
  localparam logic [KIND_W-1:0] KIND_UNUSED_LO = 3'd5;
  localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 3'd7;

  logic clk_i;
  logic rst_ni;

  bsks_req_if req_if ();
  bsks_rsp_if rsp_if ();

  bounded_stack_key_search_delete_top #(
    .CAPACITY(CAPACITY_DEF)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  stack_scoreboard sb = new(CAPACITY_DEF);

  bit src_quiet  = 1'b0;
  bit sink_quiet = 1'b0;
  int idle_cycles = 0;
  logic [KEY_W-1:0] key_pool[POOL_SIZE];

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (src_quiet || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [KIND_W-1:0] pick_kind(bit filling);
    int r;
    r = $urandom_range(0, 99);
    if (filling) begin
      if (r < 55) return KIND_PUSH;
      if (r < 65) return KIND_POP;
      if (r < 80) return KIND_SEARCH;
      if (r < 97) return KIND_DELETE;
      if (r < 98) return KIND_CLEAR;
    end else begin
      if (r < 25) return KIND_PUSH;
      if (r < 60) return KIND_POP;
      if (r < 75) return KIND_SEARCH;
      if (r < 95) return KIND_DELETE;
      if (r < 98) return KIND_CLEAR;
    end
    return KIND_UNUSED_LO + KIND_W'($urandom_range(0, KIND_UNUSED_HI - KIND_UNUSED_LO));
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 99) < 70) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom;
  endfunction

  function automatic logic [PAYLOAD_W-1:0] pick_payload();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return '1;
    return {$urandom, $urandom};
  endfunction

  // Called right after a rising edge; returns after the edge that took the word and any random gap after it
  task automatic send_word(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] key,
                           logic [PAYLOAD_W-1:0] payload);
    int gap;
    req_if.valid      <= 1'b1;
    req_if.kind       <= kind;
    req_if.key_in     <= key;
    req_if.payload_in <= payload;
    do @(posedge clk_i); while (!req_if.ready);
    sb.note_request(kind, key, payload);
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    while (sb.pending_count() > 0) @(posedge clk_i);
  endtask

  // Result side: check what was taken at this edge, then pick ready for the next
  initial begin
    stack_result_t got;
    int stall_left;
    stall_left = 0;
    rsp_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid && rsp_if.ready) begin
        got.status      = status_e'(rsp_if.status);
        got.found       = rsp_if.found;
        got.key_out     = rsp_if.key_out;
        got.payload_out = rsp_if.payload_out;
        got.count       = rsp_if.count;
        got.is_full     = rsp_if.is_full;
        got.is_empty    = rsp_if.is_empty;
        sb.check_response(got);
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else if (!sink_quiet && $urandom_range(0, 99) < 25) begin
        stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2) : $urandom_range(9, 49);
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a word
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles, %0d results still awaited",
                 idle_cycles, sb.pending_count());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    int phase_left;
    bit filling;
    int noop_words;
    phase_left = 0;
    filling = 1'b1;
    noop_words = 0;
    rst_ni            <= 1'b0;
    req_if.valid      <= 1'b0;
    req_if.kind       <= KIND_PUSH;
    req_if.key_in     <= '0;
    req_if.payload_in <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty-stack cases, extremes, duplicate keys, deletes at top/bottom/middle
    send_word(KIND_POP,    '0, '0);
    send_word(KIND_SEARCH, '0, '0);
    send_word(KIND_DELETE, '0, '0);
    send_word(KIND_PUSH,   '0, '0);
    send_word(KIND_PUSH,   '1, '1);
    send_word(KIND_PUSH,   32'h4142_4344, 64'h5555_5555_5555_5555);
    send_word(KIND_PUSH,   '0, 64'hAAAA_AAAA_AAAA_AAAA);
    send_word(KIND_SEARCH, '0, '1);
    send_word(KIND_SEARCH, 32'h1234_5678, '0);
    send_word(KIND_DELETE, '0, '0);
    send_word(KIND_DELETE, '0, '0);
    send_word(KIND_POP,    '1, '1);
    for (int k = KIND_UNUSED_LO; k <= KIND_UNUSED_HI; k++)
      send_word(KIND_W'(k), '1, '1);
    send_word(KIND_DELETE, '1, '0);
    send_word(KIND_PUSH,   32'h5858_5858, 64'h0123_4567_89AB_CDEF);
    send_word(KIND_PUSH,   32'h5959_5959, 64'hFEDC_BA98_7654_3210);
    send_word(KIND_PUSH,   32'h5A5A_5A5A, 64'h0F0F_0F0F_F0F0_F0F0);
    send_word(KIND_DELETE, 32'h5959_5959, '0);
    send_word(KIND_POP,    '0, '0);
    send_word(KIND_CLEAR,  '0, '0);
    send_word(KIND_POP,    '0, '0);
    send_word(KIND_CLEAR,  '1, '1);

    // random: alternating fill and drain phases over a small key pool so keys repeat
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (phase_left == 0) begin
        filling    = ~filling;
        phase_left = $urandom_range(30, 120);
        src_quiet  = ($urandom_range(0, 3) == 0);
        sink_quiet = ($urandom_range(0, 3) == 0);
        foreach (key_pool[i]) begin
          case ($urandom_range(0, 15))
            0:       key_pool[i] = '0;
            1:       key_pool[i] = '1;
            default: key_pool[i] = $urandom;
          endcase
        end
      end
      phase_left--;
      if (n % 400 == 399) begin
        // hold off until the block has answered everything
        req_if.valid <= 1'b0;
        @(posedge clk_i);
        wait_drained();
      end
      send_word(pick_kind(filling), pick_key(), pick_payload());
    end
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    for (int k = KIND_UNUSED_LO; k <= KIND_UNUSED_HI; k++)
      noop_words += sb.kind_count[k];
    $display("ran %0d words: push %0d, pop %0d, clear %0d, search %0d, delete %0d, no-op %0d",
             sb.checked, sb.kind_count[KIND_PUSH], sb.kind_count[KIND_POP],
             sb.kind_count[KIND_CLEAR], sb.kind_count[KIND_SEARCH], sb.kind_count[KIND_DELETE],
             noop_words);
    $display("overflow %0d, underflow %0d, key miss %0d, key hit %0d, deepest fill %0d",
             sb.overflows, sb.underflows, sb.misses, sb.hits, sb.deepest);
    if (sb.errors == 0 && sb.pending_count() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d bad results, %0d never arrived", sb.errors, sb.pending_count());
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
